// ===== sv/henon_heiles_integrator_core_defines.svh =====
// Assertion macros for the Henon-Heiles integrator core.
`ifndef HENON_HEILES_INTEGRATOR_CORE_DEFINES_SVH
`define HENON_HEILES_INTEGRATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HHI_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HHI_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HHI_ASSERT(label, clk, rstn, prop, msg)
`define HHI_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== sv/hhi_pkg.sv =====
// ----------------------------------------------------------------------------
// hhi_pkg
// Shared types, constants and saturating helpers for the integrator core.
// ----------------------------------------------------------------------------
package hhi_pkg;

    localparam int DW = 32;
    localparam int FB = 24;
    localparam int PW = 2 * DW;
    localparam int RW = 6;   // sqrt iteration counter

    typedef logic signed [DW-1:0] val_t;

    localparam val_t VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam val_t VMIN = {1'b1, {(DW-1){1'b0}}};

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_RESET = 3'd1;
    localparam logic [2:0] OP_LDX   = 3'd2;
    localparam logic [2:0] OP_LDY   = 3'd3;
    localparam logic [2:0] OP_LDVY  = 3'd4;

    localparam logic [2:0] CFG_INIT_X  = 3'd0;
    localparam logic [2:0] CFG_INIT_Y  = 3'd1;
    localparam logic [2:0] CFG_INIT_VY = 3'd2;
    localparam logic [2:0] CFG_ENERGY  = 3'd3;
    localparam logic [2:0] CFG_DT      = 3'd4;
    localparam logic [2:0] CFG_ECHO    = 3'd5;

    // datapath micro-operations
    typedef enum logic [4:0] {
        U_NOP,
        U_EMIT,     // capture state into output register
        U_M_XY,     // t0 = x*y
        U_M_YY,     // t1 = y*y
        U_M_XX,     // t2 = x*x
        U_XDD,      // t0 = -x - 2*t0
        U_YDD,      // t1 = (t1 - y) - t2
        U_M_VX,     // vx += t0*dt
        U_M_VY,     // vy += t1*dt
        U_M_PX,     // x += vx*dt
        U_M_PY,     // y += vy*dt
        U_RLOAD,    // load init regs into state
        U_R_YY,     // t1 = y*y
        U_R_Y3,     // t2 = t1*y
        U_R_C,      // t2 = floor(sat(4*t2)/3) ; t0 = sat(2e - t1)
        U_R_VV,     // t1 = vy*vy
        U_R_RAD,    // t0 = (t0 + t2) - t1 ; init sqrt
        U_SQ_STEP,  // one sqrt bit
        U_SQ_DONE   // vx = root
    } uop_t;

    typedef struct packed {
        uop_t       uop;
        logic       load;
        logic [2:0] load_op;
    } hhi_cmd_t;

    typedef struct packed {
        logic sq_last;
    } hhi_sts_t;

    typedef enum logic [2:0] {
        S_IDLE, S_RUN, S_SQRT, S_OUT
    } state_t;

    function automatic val_t sat_add(val_t a, val_t b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
        return s[DW-1:0];
    endfunction

    function automatic val_t sat_sub(val_t a, val_t b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
        return s[DW-1:0];
    endfunction

    function automatic val_t sat_neg(val_t a);
        return (a == VMIN) ? VMAX : -a;
    endfunction

    // floor(p / 2^FB) saturated; p is an exact signed product
    function automatic val_t sat_scale(logic signed [PW-1:0] p);
        logic signed [PW-1:0] q;
        q = p >>> FB;
        if (q > PW'(signed'(VMAX))) return VMAX;
        if (q < PW'(signed'(VMIN))) return VMIN;
        return q[DW-1:0];
    endfunction

endpackage

// ===== sv/hhi_datapath.sv =====
// ----------------------------------------------------------------------------
// hhi_datapath
// State registers, one shared multiplier and a bit-serial square root.
// ----------------------------------------------------------------------------
module hhi_datapath import hhi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  hhi_cmd_t    cmd,
    output hhi_sts_t    sts,
    input  val_t        load_value,
    input  val_t        cfg_init_x,
    input  val_t        cfg_init_y,
    input  val_t        cfg_init_vy,
    input  val_t        cfg_energy,
    input  logic [30:0] cfg_dt,
    output logic [4*DW-1:0] out_data
);

    // ceil(2^33 / 3): n * RECIP3 >> 33 is floor(n / 3) for any 32-bit n
    localparam logic [DW-1:0] RECIP3 = 32'hAAAA_AAAB;

    val_t x_reg, y_reg, vx_reg, vy_reg;
    val_t t0_reg, t1_reg, t2_reg;
    logic [4*DW-1:0] out_reg;
    logic [DW-2:0] root_reg;          // result below 2^(DW-1)
    logic [PW-1:0] rem_reg;           // radicand * 2^FB
    logic [RW-1:0] bit_reg;

    val_t mul_a, mul_b, mul_r;
    val_t dt;
    logic signed [PW-1:0] prod;
    logic [DW-2:0] cand;
    logic [PW-1:0] cand_sq;
    logic          div_neg;
    logic [DW-1:0] div_num;
    logic [PW-1:0] div_prod;
    logic [DW-2:0] div_quo;
    val_t          c4div;

    assign dt = val_t'({1'b0, cfg_dt});

    always_comb begin
        mul_a = x_reg;
        mul_b = y_reg;
        case (cmd.uop) inside
            U_M_YY, U_R_YY: begin mul_a = y_reg;  mul_b = y_reg;  end
            U_M_XX:         begin mul_a = x_reg;  mul_b = x_reg;  end
            U_M_VX:         begin mul_a = t0_reg; mul_b = dt;     end
            U_M_VY:         begin mul_a = t1_reg; mul_b = dt;     end
            U_M_PX:         begin mul_a = vx_reg; mul_b = dt;     end
            U_M_PY:         begin mul_a = vy_reg; mul_b = dt;     end
            U_R_Y3:         begin mul_a = t1_reg; mul_b = y_reg;  end
            U_R_VV:         begin mul_a = vy_reg; mul_b = vy_reg; end
            default:        begin mul_a = x_reg;  mul_b = y_reg;  end
        endcase
        prod  = PW'(mul_a) * PW'(mul_b);
        mul_r = sat_scale(prod);
    end

    // floor(4*y3/3) with 4*y3 saturated first
    always_comb begin
        val_t q;
        q = sat_add(t2_reg, t2_reg);
        q = sat_add(q, q);
        div_neg = q[DW-1];
        // negative: floor(q/3) = -floor((|q| + 2) / 3)
        div_num  = div_neg ? (~q + val_t'(3)) : q;
        div_prod = PW'(div_num) * PW'(RECIP3);
        div_quo  = div_prod[PW-1:DW+1];
        c4div    = div_neg ? -val_t'({1'b0, div_quo}) : val_t'({1'b0, div_quo});
    end

    always_comb begin
        cand    = root_reg | ((DW-1)'(1) << bit_reg);
        cand_sq = PW'(cand) * PW'(cand);
    end

    assign sts.sq_last = (bit_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg  <= val_t'(1 <<< FB);
            y_reg  <= val_t'(1 <<< FB);
            vx_reg <= '0;
            vy_reg <= val_t'((1 <<< FB) + ((2 <<< FB) / 5));
        end else begin
            if (cmd.load) begin
                unique case (cmd.load_op)
                    OP_LDX:  x_reg  <= load_value;
                    OP_LDY:  y_reg  <= load_value;
                    OP_LDVY: vy_reg <= load_value;
                    default: ;
                endcase
            end
            case (cmd.uop)
                U_M_VX:  vx_reg <= sat_add(vx_reg, mul_r);
                U_M_VY:  vy_reg <= sat_add(vy_reg, mul_r);
                U_M_PX:  x_reg  <= sat_add(x_reg, mul_r);
                U_M_PY:  y_reg  <= sat_add(y_reg, mul_r);
                U_RLOAD: begin
                    x_reg  <= cfg_init_x;
                    y_reg  <= cfg_init_y;
                    vy_reg <= cfg_init_vy;
                end
                // decide bit zero and write the root in the same cycle
                U_SQ_DONE: vx_reg <= val_t'({1'b0, (cand_sq <= rem_reg) ? cand : root_reg});
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.uop) inside
            U_EMIT:  out_reg <= {vy_reg, vx_reg, y_reg, x_reg};
            U_M_XY:  t0_reg <= mul_r;
            U_M_YY, U_R_YY, U_R_VV: t1_reg <= mul_r;
            U_M_XX, U_R_Y3: t2_reg <= mul_r;
            U_XDD:   t0_reg <= sat_sub(sat_neg(x_reg), sat_add(t0_reg, t0_reg));
            U_YDD:   t1_reg <= sat_sub(sat_sub(t1_reg, y_reg), t2_reg);
            U_R_C: begin
                t2_reg <= c4div;
                t0_reg <= sat_sub(sat_add(cfg_energy, cfg_energy), t1_reg);
            end
            U_R_RAD: begin
                val_t r;
                r = sat_sub(sat_add(t0_reg, t2_reg), t1_reg);
                root_reg <= '0;
                bit_reg  <= RW'(DW-2);
                rem_reg  <= r[DW-1] ? '0 : (PW'(r) << FB);
            end
            U_SQ_STEP: begin
                if (cand_sq <= rem_reg) root_reg <= cand;
                if (bit_reg != '0) bit_reg <= bit_reg - RW'(1);
            end
            default: ;
        endcase
    end

    assign out_data = out_reg;

endmodule

// ===== sv/hhi_controller.sv =====
// ----------------------------------------------------------------------------
// hhi_controller
// Sequences the micro-operations of one item and runs both handshakes.
// ----------------------------------------------------------------------------
`include "henon_heiles_integrator_core_defines.svh"
module hhi_controller import hhi_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic [2:0] in_op,
    input  logic     echo,
    output logic     out_valid,
    input  logic     out_ready,
    output hhi_cmd_t cmd,
    input  hhi_sts_t sts
);

    state_t state_reg, state_next;
    logic [3:0] pc_reg, pc_next;
    logic reset_seq_reg, reset_seq_next;
    logic emit;

    localparam logic [3:0] STEP_LAST = 4'd9;
    localparam logic [3:0] RST_LAST  = 4'd5;

    assign in_ready = (state_reg == S_IDLE);
    assign emit = (in_op == OP_TICK) ||
                  (echo && (in_op == OP_LDX || in_op == OP_LDY || in_op == OP_LDVY));

    always_comb begin
        state_next = state_reg;
        pc_next = pc_reg;
        reset_seq_next = reset_seq_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) begin
                pc_next = '0;
                if (in_op == OP_RESET) begin
                    state_next = S_RUN; reset_seq_next = 1'b1;
                end else if (emit) begin
                    state_next = S_RUN; reset_seq_next = 1'b0;
                end
            end
            S_RUN: begin
                pc_next = pc_reg + 4'd1;
                if (reset_seq_reg && pc_reg == RST_LAST) state_next = S_SQRT;
                if (!reset_seq_reg && pc_reg == STEP_LAST) state_next = S_OUT;
            end
            S_SQRT: if (sts.sq_last) state_next = S_IDLE;
            S_OUT:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd.uop = U_NOP;
        cmd.load = in_valid && in_ready;
        cmd.load_op = in_op;
        out_valid = (state_reg == S_OUT);
        unique case (state_reg)
            S_RUN: begin
                if (reset_seq_reg) begin
                    unique case (pc_reg)
                        4'd0: cmd.uop = U_RLOAD;
                        4'd1: cmd.uop = U_R_YY;
                        4'd2: cmd.uop = U_R_Y3;
                        4'd3: cmd.uop = U_R_C;
                        4'd4: cmd.uop = U_R_VV;
                        4'd5: cmd.uop = U_R_RAD;
                        default: cmd.uop = U_NOP;
                    endcase
                end else begin
                    unique case (pc_reg)
                        4'd0: cmd.uop = U_EMIT;
                        4'd1: cmd.uop = U_M_XY;
                        4'd2: cmd.uop = U_M_YY;
                        4'd3: cmd.uop = U_M_XX;
                        4'd4: cmd.uop = U_XDD;
                        4'd5: cmd.uop = U_YDD;
                        4'd6: cmd.uop = U_M_VX;
                        4'd7: cmd.uop = U_M_VY;
                        4'd8: cmd.uop = U_M_PX;
                        4'd9: cmd.uop = U_M_PY;
                        default: cmd.uop = U_NOP;
                    endcase
                end
            end
            S_SQRT: cmd.uop = sts.sq_last ? U_SQ_DONE : U_SQ_STEP;
            default: cmd.uop = U_NOP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pc_reg <= '0;
            reset_seq_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg <= pc_next;
            reset_seq_reg <= reset_seq_next;
        end
    end

    `HHI_ASSERT(a_out_only_out, aclk, aresetn, out_valid |-> state_reg == S_OUT, "out_valid outside output state")
    `HHI_ASSERT(a_hold_out, aclk, aresetn, (out_valid && !out_ready) |=> out_valid, "result dropped while stalled")
    `HHI_ASSERT(a_no_accept_busy, aclk, aresetn, (state_reg != S_IDLE) |-> !in_ready, "accepted item while busy")
    `HHI_ASSERT(a_run_pc, aclk, aresetn, (state_reg == S_RUN) |-> pc_reg <= STEP_LAST, "sequence counter overran")

endmodule

// ===== sv/henon_heiles_integrator_core.sv =====
// ----------------------------------------------------------------------------
// henon_heiles_integrator_core
// Henon-Heiles semi-implicit Euler integrator, Q8.24 saturating arithmetic.
// ----------------------------------------------------------------------------
// Tick: the sequencer steps through one shared 32x32 multiplier, then the result
// beat is offered and held until taken; no new item is accepted before that.
// Reset item: the six reset micro-operations, then 31 square-root bit steps,
// the last of which writes x velocity. Loads without echo complete while idle.
// aresetn resets control, state and config registers; temporaries and output are not.
module henon_heiles_integrator_core import hhi_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // [2:0] op, [34:3] load_value, rest zero
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // out_x, out_y, out_x_velocity, out_y_velocity
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    val_t init_x_reg, init_y_reg, init_vy_reg, energy_reg;
    logic [30:0] dt_reg;
    logic echo_reg;
    hhi_cmd_t cmd;
    hhi_sts_t sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_x_reg  <= val_t'(32'd16777216);
            init_y_reg  <= val_t'(32'd16777216);
            init_vy_reg <= val_t'(32'd23488102);
            energy_reg  <= val_t'(32'd2097152);
            dt_reg      <= 31'd335544;
            echo_reg    <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_INIT_X:  init_x_reg  <= cfg_data;
                CFG_INIT_Y:  init_y_reg  <= cfg_data;
                CFG_INIT_VY: init_vy_reg <= cfg_data;
                CFG_ENERGY:  energy_reg  <= cfg_data;
                CFG_DT:      dt_reg      <= cfg_data[30:0];
                CFG_ECHO:    echo_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    hhi_controller u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_op(s_tdata[2:0]),
        .echo(echo_reg), .out_valid(m_tvalid), .out_ready(m_tready),
        .cmd, .sts
    );

    hhi_datapath u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .load_value(s_tdata[34:3]),
        .cfg_init_x(init_x_reg), .cfg_init_y(init_y_reg),
        .cfg_init_vy(init_vy_reg), .cfg_energy(energy_reg),
        .cfg_dt(dt_reg), .out_data(m_tdata)
    );

endmodule
